// ----- hdl/ble_adv_report_filter_unit_assert.svh -----
// assertion macros for the advertising report filter
// expects clk_i and rst_ni in the scope of the including module
`ifndef BLE_ADV_REPORT_FILTER_UNIT_ASSERT_SVH
`define BLE_ADV_REPORT_FILTER_UNIT_ASSERT_SVH

// property holds at every clock edge outside reset
`define BLEAF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression never becomes true outside reset
`define BLEAF_ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ----- hdl/bleaf_pkg.sv -----
// types and constants of the advertising report filter
// no dependencies
`default_nettype none

package bleaf_pkg;

  // configuration register indexes
  typedef enum logic [7:0] {
    CFG_RSSI_FLOOR     = 8'd0,
    CFG_EXPECTED_NAME  = 8'd1,
    CFG_ID_POS         = 8'd2,
    CFG_RADIO_POS      = 8'd3,
    CFG_NETWORK_POS    = 8'd4,
    CFG_LEVEL_MASK     = 8'd5,
    CFG_LEVEL_SHIFT    = 8'd6,
    CFG_MIN_LEVEL      = 8'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_CNAME = 2'd1,
    KIND_SNAME = 2'd2,
    KIND_MANUF = 2'd3
  } kind_e;

  localparam logic [7:0] AD_TYPE_CNAME = 8'h09;
  localparam logic [7:0] AD_TYPE_SNAME = 8'h08;
  localparam logic [7:0] AD_TYPE_MANUF = 8'hFF;

  // bytes held in the expected name register
  localparam int NAME_REG_BYTES = 3;

  localparam logic signed [7:0] RSSI_FLOOR_RST    = -8'sd100;
  localparam logic [23:0]       EXPECTED_NAME_RST = 24'h415344;

  typedef struct packed {
    logic manuf_ok;
    logic manuf_found;
    logic sname_ok;
    logic sname_found;
    logic cname_ok;
    logic cname_found;
  } match_flags_t;

  typedef struct packed {
    logic       accepted;
    logic       latched;
    logic [7:0] device_id;
    logic [7:0] radio_status;
    logic [7:0] network_status;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/ble_adv_report_filter_unit.sv -----
// advertising report filter: walks the AD structures of one report a byte at a time
// and gives one verdict per report; uses bleaf_pkg and the assertion macro header
// the verdict is registered after the transfer of the last byte, into the skid entry if the output stalls
// throughput: one byte per cycle while in_stall_o is low; the parse state updates on each transferred byte
// a two-entry result buffer keeps bytes flowing while one verdict waits downstream
// reset: configuration to defaults, parse state, held status and result buffer cleared
`default_nettype none

module ble_adv_report_filter_unit #(
  parameter int NAME_BYTES       = 3,
  parameter int PAYLOAD_BYTES    = 3,
  parameter int MAX_REPORT_BYTES = 31
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [7:0]        cfg_index_i,
  input  wire logic [23:0]       cfg_data_i,
  // byte stream
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              byte_valid_i,
  input  wire logic              first_i,
  input  wire logic              last_i,
  input  wire logic signed [7:0] rssi_i,
  // verdicts
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   accepted_o,
  output logic                   status_latched_o,
  output logic [7:0]             device_id_o,
  output logic [7:0]             radio_status_o,
  output logic [7:0]             network_status_o
);

  // configuration registers
  logic signed [7:0] rssi_floor_q;
  logic [23:0]       expected_name_q;
  logic [1:0]        id_pos_q, radio_pos_q, network_pos_q;
  logic [7:0]        level_mask_q;
  logic [2:0]        level_shift_q;
  logic [7:0]        min_level_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rssi_floor_q    <= bleaf_pkg::RSSI_FLOOR_RST;
      expected_name_q <= bleaf_pkg::EXPECTED_NAME_RST;
      id_pos_q        <= 2'd0;
      radio_pos_q     <= 2'd1;
      network_pos_q   <= 2'd2;
      level_mask_q    <= 8'hFF;
      level_shift_q   <= 3'd0;
      min_level_q     <= 8'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bleaf_pkg::CFG_RSSI_FLOOR:    rssi_floor_q    <= signed'(cfg_data_i[7:0]);
        bleaf_pkg::CFG_EXPECTED_NAME: expected_name_q <= cfg_data_i;
        bleaf_pkg::CFG_ID_POS:        id_pos_q        <= cfg_data_i[1:0];
        bleaf_pkg::CFG_RADIO_POS:     radio_pos_q     <= cfg_data_i[1:0];
        bleaf_pkg::CFG_NETWORK_POS:   network_pos_q   <= cfg_data_i[1:0];
        bleaf_pkg::CFG_LEVEL_MASK:    level_mask_q    <= cfg_data_i[7:0];
        bleaf_pkg::CFG_LEVEL_SHIFT:   level_shift_q   <= cfg_data_i[2:0];
        bleaf_pkg::CFG_MIN_LEVEL:     min_level_q     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // parse state
  logic [7:0]                     byte_offset_q, byte_offset_d;
  logic [7:0]                     remaining_q, remaining_d;
  logic [7:0]                     cur_len_q, cur_len_d;
  bleaf_pkg::kind_e               kind_q, kind_d;
  logic                           stopped_q, stopped_d;
  logic                           good_q, good_d;
  logic [PAYLOAD_BYTES-1:0][7:0]  capture_q, capture_d;
  logic [PAYLOAD_BYTES-1:0][7:0]  committed_q, committed_d;
  bleaf_pkg::match_flags_t        flags_q, flags_d;
  logic [7:0]                     held_id_q, held_id_d;
  logic [7:0]                     held_radio_q, held_radio_d;
  logic [7:0]                     held_net_q, held_net_d;

  logic                           in_xfer;
  logic [7:0]                     pay_idx;
  logic [7:0]                     name_byte;
  logic                           name_ok;
  logic [7:0]                     pick_id, pick_radio, pick_net, level;
  bleaf_pkg::result_t             result;
  logic                           result_valid;

  function automatic logic [7:0] pick(input logic [PAYLOAD_BYTES-1:0][7:0] payload,
                                      input logic [1:0] pos);
    logic [7:0] r;
    r = 8'h00;
    for (int k = 0; k < PAYLOAD_BYTES; k++) begin
      if (int'(pos) == k) r = payload[k];
    end
    return r;
  endfunction

  assign in_xfer = in_valid_i && !in_stall_o;

  always_comb begin
    byte_offset_d = byte_offset_q;
    remaining_d   = remaining_q;
    cur_len_d     = cur_len_q;
    kind_d        = kind_q;
    stopped_d     = stopped_q;
    good_d        = good_q;
    capture_d     = capture_q;
    committed_d   = committed_q;
    flags_d       = flags_q;
    held_id_d     = held_id_q;
    held_radio_d  = held_radio_q;
    held_net_d    = held_net_q;
    pay_idx       = 8'd0;
    name_byte     = 8'd0;
    name_ok       = 1'b0;
    pick_id       = 8'd0;
    pick_radio    = 8'd0;
    pick_net      = 8'd0;
    level         = 8'd0;
    result        = '0;
    result_valid  = 1'b0;

    if (in_xfer && first_i) begin
      byte_offset_d = '0;
      remaining_d   = '0;
      cur_len_d     = '0;
      kind_d        = bleaf_pkg::KIND_OTHER;
      stopped_d     = 1'b0;
      good_d        = 1'b0;
      capture_d     = '0;
      committed_d   = '0;
      flags_d       = '0;
    end

    if (in_xfer && byte_valid_i && !stopped_d &&
        (byte_offset_d < 8'(MAX_REPORT_BYTES))) begin
      byte_offset_d = byte_offset_d + 8'd1;
      if (remaining_d == 8'd0) begin
        // length byte, zero ends the parse
        if (data_byte_i == 8'd0) begin
          stopped_d = 1'b1;
        end else begin
          cur_len_d   = data_byte_i;
          remaining_d = data_byte_i;
        end
      end else begin
        if (remaining_d == cur_len_d) begin
          // type byte, only the first structure of each kind counts
          kind_d = bleaf_pkg::KIND_OTHER;
          if (data_byte_i == bleaf_pkg::AD_TYPE_CNAME && !flags_d.cname_found) begin
            kind_d = bleaf_pkg::KIND_CNAME;
          end else if (data_byte_i == bleaf_pkg::AD_TYPE_SNAME && !flags_d.sname_found) begin
            kind_d = bleaf_pkg::KIND_SNAME;
          end else if (data_byte_i == bleaf_pkg::AD_TYPE_MANUF && !flags_d.manuf_found) begin
            kind_d = bleaf_pkg::KIND_MANUF;
          end
          good_d    = 1'b1;
          capture_d = '0;
        end else begin
          pay_idx = cur_len_d - 8'd1 - remaining_d;
          // name bytes past the register compare against zero
          if (pay_idx < 8'(bleaf_pkg::NAME_REG_BYTES)) begin
            name_byte = expected_name_q[8*pay_idx[1:0] +: 8];
          end
          if (kind_d == bleaf_pkg::KIND_CNAME || kind_d == bleaf_pkg::KIND_SNAME) begin
            if (!(pay_idx < 8'(NAME_BYTES)) || data_byte_i != name_byte) good_d = 1'b0;
          end else if (kind_d == bleaf_pkg::KIND_MANUF) begin
            for (int k = 0; k < PAYLOAD_BYTES; k++) begin
              if (int'(pay_idx) == k) capture_d[k] = data_byte_i;
            end
          end
        end
        remaining_d = remaining_d - 8'd1;
        if (remaining_d == 8'd0) begin
          // structure complete
          case (kind_d)
            bleaf_pkg::KIND_CNAME: begin
              flags_d.cname_found = 1'b1;
              if (good_d && cur_len_d == 8'(NAME_BYTES + 1)) flags_d.cname_ok = 1'b1;
            end
            bleaf_pkg::KIND_SNAME: begin
              flags_d.sname_found = 1'b1;
              if (good_d && cur_len_d == 8'(NAME_BYTES + 1)) flags_d.sname_ok = 1'b1;
            end
            bleaf_pkg::KIND_MANUF: begin
              flags_d.manuf_found = 1'b1;
              if (cur_len_d == 8'(PAYLOAD_BYTES + 1)) begin
                flags_d.manuf_ok = 1'b1;
                committed_d      = capture_d;
              end
            end
            default: ;
          endcase
          kind_d = bleaf_pkg::KIND_OTHER;
        end
      end
    end

    if (in_xfer && last_i) begin
      name_ok    = flags_d.cname_found ? flags_d.cname_ok : flags_d.sname_ok;
      pick_id    = pick(committed_d, id_pos_q);
      pick_radio = pick(committed_d, radio_pos_q);
      pick_net   = pick(committed_d, network_pos_q);
      level      = (pick_net & level_mask_q) >> level_shift_q;
      if ((rssi_i > rssi_floor_q) && name_ok && flags_d.manuf_ok) begin
        held_id_d       = pick_id;
        held_radio_d    = pick_radio;
        held_net_d      = pick_net;
        result.latched  = 1'b1;
        result.accepted = (level >= min_level_q);
      end
      result.device_id      = held_id_d;
      result.radio_status   = held_radio_d;
      result.network_status = held_net_d;
      result_valid          = 1'b1;
      // a report without its first mark starts clean
      byte_offset_d = '0;
      remaining_d   = '0;
      cur_len_d     = '0;
      kind_d        = bleaf_pkg::KIND_OTHER;
      stopped_d     = 1'b0;
      good_d        = 1'b0;
      capture_d     = '0;
      committed_d   = '0;
      flags_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_offset_q <= '0;
      remaining_q   <= '0;
      cur_len_q     <= '0;
      kind_q        <= bleaf_pkg::KIND_OTHER;
      stopped_q     <= 1'b0;
      good_q        <= 1'b0;
      capture_q     <= '0;
      committed_q   <= '0;
      flags_q       <= '0;
      held_id_q     <= '0;
      held_radio_q  <= '0;
      held_net_q    <= '0;
    end else begin
      byte_offset_q <= byte_offset_d;
      remaining_q   <= remaining_d;
      cur_len_q     <= cur_len_d;
      kind_q        <= kind_d;
      stopped_q     <= stopped_d;
      good_q        <= good_d;
      capture_q     <= capture_d;
      committed_q   <= committed_d;
      flags_q       <= flags_d;
      held_id_q     <= held_id_d;
      held_radio_q  <= held_radio_d;
      held_net_q    <= held_net_d;
    end
  end

  // result register with a skid entry behind it
  logic               out_valid_q, skid_valid_q;
  bleaf_pkg::result_t out_q, skid_q;
  logic               out_xfer;

  assign out_xfer   = out_valid_q && !out_stall_i;
  assign in_stall_o = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_xfer) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= result_valid;
      end
    end else if (result_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_xfer) begin
      out_q <= skid_valid_q ? skid_q : result;
    end else if (result_valid) begin
      skid_q <= result;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign accepted_o       = out_q.accepted;
  assign status_latched_o = out_q.latched;
  assign device_id_o      = out_q.device_id;
  assign radio_status_o   = out_q.radio_status;
  assign network_status_o = out_q.network_status;

`include "ble_adv_report_filter_unit_assert.svh"

  `BLEAF_ASSERT_NEVER(a_skid_without_out, skid_valid_q && !out_valid_q, "skid full, output empty")
  `BLEAF_ASSERT(a_accept_needs_latch, (out_valid_o && accepted_o) |-> status_latched_o, "accepted without latch")
  `BLEAF_ASSERT(a_offset_bound, byte_offset_q <= 8'(MAX_REPORT_BYTES), "byte offset past report limit")
  `BLEAF_ASSERT(a_remaining_bound, remaining_q <= cur_len_q, "structure count exceeds its length")

endmodule

`default_nettype wire
